// ===== src/cw_frame_delay_checker_core_assert.svh =====
// assertion macros for the morse frame delay checker
`ifndef CW_FRAME_DELAY_CHECKER_CORE_ASSERT_SVH
`define CW_FRAME_DELAY_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define CWFDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CWFDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CWFDC_ASSERT(lbl, clk, rst, prop, msg)
`define CWFDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/cwfdc_pkg.sv =====
// types and constants for the morse frame delay checker
`default_nettype none

package cwfdc_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 7;
  localparam int unsigned MAG_W       = 13;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned PAIR_W      = 14;

  localparam logic [CHAR_W-1:0]  CH_FIRST    = 8'd33;
  localparam logic [CHAR_W-1:0]  CH_LAST     = 8'd126;
  localparam logic [CHAR_W-1:0]  CH_ESCAPE   = 8'd126;
  localparam logic [PAIR_W-1:0]  RADIX       = 14'd94;
  localparam logic [PAIR_W-1:0]  PAIR_BIAS   = 14'd4418;
  localparam logic [DIGIT_W-1:0] SINGLE_BIAS = 7'd46;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd3000;
  localparam logic [LIMIT_W-1:0] SUM_MAX     = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_CH2   = 3'd1,
    PH_D1    = 3'd2,
    PH_D2    = 3'd3,
    PH_X1    = 3'd4,
    PH_X2    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_CHAR   = 3'd1,
    ERR_UNFINISHED = 3'd2,
    ERR_ZERO_DELAY = 3'd3,
    ERR_LONG_DELAY = 3'd4,
    ERR_LONG_SUM   = 3'd5,
    ERR_NO_EVENT   = 3'd6
  } err_t;

  typedef struct packed {
    logic             number_ready;
    logic             is_channel;
    logic [MAG_W-1:0] value_mag;
    logic             key_down;
    logic             frame_done;
    logic             frame_ok;
    err_t             error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== src/cw_frame_delay_checker_core.sv =====
// morse frame body checker: decodes channel and key delays, checks the frame
//
// input stream: one body character per item, starting just after the header.
//   s_axis_tdata carries the character, s_axis_tuser the format bit (sampled on
//   the first printable character of a frame), s_axis_tlast marks the last one.
// output stream: one item for each character that completes a number or ends
//   the frame. m_axis_tuser tells whether a number is present and whether it is
//   the channel; m_axis_tlast marks the frame verdict.
// the result is registered, in the output register or, on a stall, the skid
//   register. throughput: one character per cycle; the decode, the bound checks
//   and the sum update all sit between the frame state and the result register.
// a downstream stall parks one result in a skid register; s_axis_tready drops
//   only while that skid register is full, so up to two results wait in the block.
// characters that complete nothing produce no output item.
// delay_limit is written through cfg_we/cfg_wdata; the user must write it only while idle, not enforced by the block.
// reset (rst, synchronous) clears the frame state, empties both result registers
//   and sets delay_limit to 3000.
`default_nettype none

module cw_frame_delay_checker_core
  import cwfdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,     // delay_limit
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // char_code
  input  wire logic        s_axis_tuser,  // extended_format
  input  wire logic        s_axis_tlast,  // end_of_frame
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // value_mag[12:0], key_down, frame_ok,
                                          // error_code[2:0], zero pad
  output logic [1:0]       m_axis_tuser,  // number_ready, is_channel
  output logic             m_axis_tlast   // frame_done
);

  logic [LIMIT_W-1:0]  delay_limit;
  phase_t              phase, phase_next;
  logic [DIGIT_W-1:0]  held_char, held_char_next;
  logic                format_flag, format_flag_next;
  logic [LIMIT_W-1:0]  delay_sum, delay_sum_next;
  err_t                sticky_error, sticky_error_next;
  logic                event_seen, event_seen_next;

  result_t             out_res, skid_res, res;
  logic                out_valid, skid_valid;
  logic                have_res;

  logic                accept, drain;
  logic                printable;
  logic [DIGIT_W-1:0]  digit;
  logic [PAIR_W-1:0]   pair_raw;
  logic [MAG_W-1:0]    pair_mag, single_mag, mag;
  logic                pair_kd, single_kd;
  logic                is_pair, have_delay, ready;
  logic [LIMIT_W:0]    sum_wide;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign drain  = out_valid && m_axis_tready;

  assign printable = (s_axis_tdata >= CH_FIRST) && (s_axis_tdata <= CH_LAST);
  assign digit     = DIGIT_W'(s_axis_tdata - CH_FIRST);

  // second character of a pair completes a two-character number
  assign is_pair = (phase == PH_CH2) || (phase == PH_D2) || (phase == PH_X2);

  // base-94 pair and single-character decode
  assign pair_raw   = PAIR_W'(held_char) * RADIX + PAIR_W'(digit);
  assign pair_kd    = pair_raw > PAIR_BIAS;
  assign pair_mag   = (pair_raw >= PAIR_BIAS) ? MAG_W'(pair_raw - PAIR_BIAS)
                                              : MAG_W'(PAIR_BIAS - pair_raw);
  assign single_kd  = digit > SINGLE_BIAS;
  assign single_mag = (digit >= SINGLE_BIAS) ? MAG_W'(digit - SINGLE_BIAS)
                                             : MAG_W'(SINGLE_BIAS - digit);
  assign mag        = is_pair ? pair_mag : single_mag;
  assign sum_wide   = (LIMIT_W + 1)'(delay_sum) + (LIMIT_W + 1)'(mag);

  always_comb begin
    phase_next        = phase;
    held_char_next    = held_char;
    format_flag_next  = (phase == PH_START) ? s_axis_tuser : format_flag;
    delay_sum_next    = delay_sum;
    sticky_error_next = sticky_error;
    event_seen_next   = event_seen;
    have_delay        = 1'b0;
    ready             = 1'b0;
    res               = '0;

    if (!printable) begin
      if (sticky_error == ERR_NONE) begin
        sticky_error_next = ERR_BAD_CHAR;
      end
    end else begin
      unique case (phase)
        PH_START: begin
          held_char_next = digit;
          phase_next     = PH_CH2;
        end
        PH_CH2: begin
          ready          = 1'b1;
          res.is_channel = 1'b1;
          phase_next     = PH_D1;
        end
        PH_D1: begin
          if (format_flag) begin
            if (s_axis_tdata == CH_ESCAPE) begin
              phase_next = PH_X1;
            end else begin
              have_delay = 1'b1;
            end
          end else begin
            held_char_next = digit;
            phase_next     = PH_D2;
          end
        end
        PH_D2, PH_X2: begin
          have_delay = 1'b1;
          phase_next = PH_D1;
        end
        PH_X1: begin
          held_char_next = digit;
          phase_next     = PH_X2;
        end
        default: phase_next = PH_START;
      endcase
    end

    if (have_delay) begin
      ready = 1'b1;
    end
    if (ready) begin
      res.number_ready = 1'b1;
      res.value_mag    = mag;
      res.key_down     = is_pair ? pair_kd : single_kd;
    end

    // delay checks in order: zero, long, long sum
    if (have_delay) begin
      event_seen_next = 1'b1;
      if (sticky_error == ERR_NONE) begin
        if (mag == '0) begin
          sticky_error_next = ERR_ZERO_DELAY;
        end else if (LIMIT_W'(mag) >= delay_limit) begin
          sticky_error_next = ERR_LONG_DELAY;
        end else begin
          delay_sum_next = sum_wide[LIMIT_W] ? SUM_MAX : sum_wide[LIMIT_W-1:0];
          if (delay_sum_next >= delay_limit) begin
            sticky_error_next = ERR_LONG_SUM;
          end
        end
      end
    end

    if (s_axis_tlast) begin
      if (sticky_error_next == ERR_NONE) begin
        if (phase_next != PH_D1) begin
          sticky_error_next = ERR_UNFINISHED;
        end else if (!event_seen_next) begin
          sticky_error_next = ERR_NO_EVENT;
        end
      end
      res.frame_done    = 1'b1;
      res.error_code    = sticky_error_next;
      res.frame_ok      = (sticky_error_next == ERR_NONE);
      phase_next        = PH_START;
      held_char_next    = '0;
      format_flag_next  = 1'b0;
      delay_sum_next    = '0;
      sticky_error_next = ERR_NONE;
      event_seen_next   = 1'b0;
    end

    have_res = ready || s_axis_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      delay_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      held_char    <= '0;
      format_flag  <= 1'b0;
      delay_sum    <= '0;
      sticky_error <= ERR_NONE;
      event_seen   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      held_char    <= held_char_next;
      format_flag  <= format_flag_next;
      delay_sum    <= delay_sum_next;
      sticky_error <= sticky_error_next;
      event_seen   <= event_seen_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept && have_res) begin
      if (!out_valid || drain) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (drain) begin
        out_res <= skid_res;
      end
    end else if (accept && have_res) begin
      if (!out_valid || drain) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_res.error_code, out_res.frame_ok,
                          out_res.key_down, out_res.value_mag};
  assign m_axis_tuser  = {out_res.is_channel, out_res.number_ready};
  assign m_axis_tlast  = out_res.frame_done;

`include "cw_frame_delay_checker_core_assert.svh"

  `CWFDC_ASSERT(a_skid_needs_out, clk, rst, !skid_valid || out_valid, "skid full while output empty")
  `CWFDC_ASSERT(a_out_has_content, clk, rst, !out_valid || out_res.number_ready || out_res.frame_done, "empty result item")
  `CWFDC_ASSERT(a_ok_is_clean, clk, rst, !(out_valid && out_res.frame_ok) || (out_res.frame_done && out_res.error_code == ERR_NONE), "frame_ok with error or without frame end")
  `CWFDC_ASSERT(a_sum_inside_frame, clk, rst, delay_sum == '0 || phase != PH_START, "delay sum left over at frame start")
  `CWFDC_ASSERT_NEXT(a_error_sticks, clk, rst, sticky_error != ERR_NONE && !(accept && s_axis_tlast), sticky_error == $past(sticky_error), "sticky error changed inside frame")

endmodule

`default_nettype wire

// ===== tb/cw_frame_delay_checker_core_tb.sv =====
// testbench for cw_frame_delay_checker_core: random and directed frames checked against a local decoder
module cw_frame_delay_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cwfdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // char_code
  logic        s_axis_tuser = 1'b0; // extended_format
  logic        s_axis_tlast = 1'b0; // end_of_frame
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // value_mag[12:0], key_down, frame_ok, error_code[2:0], pad
  logic [1:0]  m_axis_tuser;        // number_ready, is_channel
  logic        m_axis_tlast;        // frame_done

  cw_frame_delay_checker_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // decoder state mirrored from the block
  phase_t      fr_phase;
  logic [6:0]  fr_digit;
  bit          fr_ext;
  logic [15:0] fr_sum;
  err_t        fr_err;
  bit          fr_event;
  logic [15:0] cur_limit = LIMIT_RESET;

  result_t     decoded_q[$];
  result_t     want;
  logic [7:0]  body_q[$];

  int  chars_sent = 0;
  int  frames_sent = 0;
  int  results_checked = 0;
  int  fail_count = 0;
  int  stuck_cycles = 0;
  int  rx_hold = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  function automatic void clear_frame();
    fr_phase = PH_START;
    fr_digit = '0;
    fr_ext   = 1'b0;
    fr_sum   = '0;
    fr_err   = ERR_NONE;
    fr_event = 1'b0;
  endfunction

  function automatic int pair_value(input logic [6:0] hi, input logic [6:0] lo);
    return int'(hi) * int'(RADIX) + int'(lo) - int'(PAIR_BIAS);
  endfunction

  function automatic bit decode_char(input logic [7:0] c, input bit ext, input bit eof,
                                     output result_t r);
    logic [6:0] dig;
    int val;
    int mag;
    int s;
    bit got_delay;
    r = '0;
    val = 0;
    mag = 0;
    got_delay = 1'b0;
    if (fr_phase == PH_START) fr_ext = ext;
    if (c < CH_FIRST || c > CH_LAST) begin
      if (fr_err == ERR_NONE) fr_err = ERR_BAD_CHAR;
    end else begin
      dig = 7'(c - CH_FIRST);
      case (fr_phase)
        PH_START: begin
          fr_digit = dig;
          fr_phase = PH_CH2;
        end
        PH_CH2: begin
          val = pair_value(fr_digit, dig);
          r.number_ready = 1'b1;
          r.is_channel = 1'b1;
          fr_phase = PH_D1;
        end
        PH_D1: begin
          if (!fr_ext) begin
            fr_digit = dig;
            fr_phase = PH_D2;
          end else if (c == CH_ESCAPE) begin
            fr_phase = PH_X1;
          end else begin
            val = int'(dig) - int'(SINGLE_BIAS);
            got_delay = 1'b1;
          end
        end
        PH_D2, PH_X2: begin
          val = pair_value(fr_digit, dig);
          got_delay = 1'b1;
          fr_phase = PH_D1;
        end
        PH_X1: begin
          fr_digit = dig;
          fr_phase = PH_X2;
        end
        default: fr_phase = PH_START;
      endcase
      if (got_delay) r.number_ready = 1'b1;
      if (r.number_ready) begin
        mag = (val < 0) ? -val : val;
        r.value_mag = MAG_W'(mag);
        r.key_down = (val > 0);
      end
      if (got_delay) begin
        fr_event = 1'b1;
        if (fr_err == ERR_NONE) begin
          if (mag == 0) begin
            fr_err = ERR_ZERO_DELAY;
          end else if (mag >= int'(cur_limit)) begin
            fr_err = ERR_LONG_DELAY;
          end else begin
            s = int'(fr_sum) + mag;
            if (s > int'(SUM_MAX)) s = int'(SUM_MAX);
            fr_sum = 16'(s);
            if (s >= int'(cur_limit)) fr_err = ERR_LONG_SUM;
          end
        end
      end
    end
    if (eof) begin
      r.frame_done = 1'b1;
      if (fr_err == ERR_NONE) begin
        if (fr_phase != PH_D1) fr_err = ERR_UNFINISHED;
        else if (!fr_event) fr_err = ERR_NO_EVENT;
      end
      r.error_code = fr_err;
      r.frame_ok = (fr_err == ERR_NONE);
      clear_frame();
    end
    return r.number_ready || r.frame_done;
  endfunction

  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= 50) $display("%0t: result %0d: %s", $realtime, results_checked, msg);
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val) report_fail($sformatf("%s got %0d want %0d", name, got, exp_val));
  endtask

  // result checking and watchdog, sampled between edges
  always @(negedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          report_fail("result with nothing expected");
        end else begin
          want = decoded_q.pop_front();
          check_field("number_ready", int'(m_axis_tuser[0]), int'(want.number_ready));
          check_field("is_channel", int'(m_axis_tuser[1]), int'(want.is_channel));
          check_field("value_mag", int'(m_axis_tdata[12:0]), int'(want.value_mag));
          check_field("key_down", int'(m_axis_tdata[13]), int'(want.key_down));
          check_field("frame_done", int'(m_axis_tlast), int'(want.frame_done));
          check_field("frame_ok", int'(m_axis_tdata[14]), int'(want.frame_ok));
          check_field("error_code", int'(m_axis_tdata[17:15]), int'(want.error_code));
        end
        results_checked++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", stuck_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver: long hold when asked, random stall bursts otherwise
  initial begin
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
        @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input bit ext, input bit eof);
    result_t r;
    bit hit;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= ext;
    s_axis_tlast  <= eof;
    do begin
      @(negedge clk);
      hit = s_axis_tready;
      @(posedge clk);
    end while (!hit);
    chars_sent++;
    if (eof) frames_sent++;
    if (decode_char(c, ext, eof, r)) decoded_q.push_back(r);
  endtask

  task automatic send_body(input bit ext);
    for (int i = 0; i < body_q.size(); i++)
      send_char(body_q[i], (i == 0) ? ext : bit'($urandom_range(0, 1)), i == body_q.size() - 1);
    body_q.delete();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = v;
  endtask

  function automatic void push_pair(input int v);
    int n;
    n = v + int'(PAIR_BIAS);
    body_q.push_back(8'(n / int'(RADIX)) + CH_FIRST);
    body_q.push_back(8'(n % int'(RADIX)) + CH_FIRST);
  endfunction

  function automatic void push_single(input int v);
    body_q.push_back(8'(v + int'(SINGLE_BIAS)) + CH_FIRST);
  endfunction

  function automatic void push_delay(input int v, input bit ext);
    if (ext && v >= -46 && v <= 46 && $urandom_range(0, 3) != 0) begin
      push_single(v);
    end else begin
      if (ext) body_q.push_back(CH_ESCAPE);
      push_pair(v);
    end
  endfunction

  function automatic int pick_delay(input bit big);
    int r;
    int mag;
    r = $urandom_range(0, 15);
    if (r == 0) mag = 0;
    else if (big) mag = $urandom_range(1500, 4417);
    else if (r <= 8) mag = $urandom_range(1, 46);
    else if (r <= 13) mag = $urandom_range(47, 700);
    else if (r == 14) mag = $urandom_range(701, 4417);
    else return $urandom_range(0, 1) ? 4417 : -4418;
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  // mostly well-formed frames, the rest broken or noise
  task automatic random_frame(input int max_delays, input bit big);
    int kind;
    int n;
    bit ext;
    logic [7:0] bad;
    ext  = bit'($urandom_range(0, 1));
    kind = $urandom_range(0, 11);
    bad  = $urandom_range(0, 1) ? 8'($urandom_range(0, 32)) : 8'($urandom_range(127, 255));
    if (kind == 11) begin
      repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      push_pair($urandom_range(0, 8835) - 4418);
      n = (kind == 10) ? 0 : $urandom_range(1, max_delays);
      repeat (n) push_delay(pick_delay(big), ext);
      if (kind == 8) body_q.insert($urandom_range(0, body_q.size()), bad);
      if (kind == 9) begin
        if (ext && $urandom_range(0, 1)) body_q.push_back(CH_ESCAPE);
        else void'(body_q.pop_back());
      end
    end
    send_body(ext);
  endtask

  task automatic run_frames(input int n_chars, input int max_delays, input bit big);
    int stop;
    stop = chars_sent + n_chars;
    while (chars_sent < stop) random_frame(max_delays, big);
  endtask

  task automatic test_channel_extremes();
    push_pair(4417);
    push_pair(2000);
    push_pair(-1500);
    push_pair(-4418);
    send_body(1'b0);
  endtask

  task automatic test_extended_format();
    push_pair(-4418);
    push_single(-46);
    push_single(46);
    body_q.push_back(CH_ESCAPE);
    push_pair(-1378);
    push_single(0);
    send_body(1'b1);
  endtask

  // format comes from the first printable character, bad ones are skipped
  task automatic test_bad_characters();
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'd65, 1'b1, 1'b0);
    send_char(8'd65, 1'b0, 1'b0);
    send_char(8'd80, 1'b0, 1'b0);
    send_char(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_frame_end_errors();
    push_pair(100);
    push_pair(7);
    void'(body_q.pop_back());
    send_body(1'b0);
    push_pair(-1);
    send_body(1'b1);
    push_pair(3);
    body_q.push_back(CH_ESCAPE);
    send_body(1'b1);
  endtask

  task automatic test_limit_sweep();
    set_limit(16'd1);
    run_frames(50, 6, 1'b0);
    set_limit(16'd0);
    run_frames(50, 6, 1'b0);
    set_limit(16'hFFFF);
    run_frames(90, 30, 1'b1);
    set_limit(16'($urandom_range(2, 500)));
    run_frames(60, 6, 1'b0);
    set_limit(16'($urandom_range(501, 65534)));
    run_frames(60, 6, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering, the block must stall its input
  task automatic test_backpressure();
    set_limit(LIMIT_RESET);
    tx_idle_on = 1'b0;
    rx_hold = 80;
    run_frames(40, 6, 1'b0);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 6; chunk++) begin
      set_limit((chunk % 2) ? 16'($urandom_range(100, 8000)) : LIMIT_RESET);
      tx_idle_on = (chunk == 0) ? 1'b1 : bit'($urandom_range(0, 1));
      rx_idle_on = (chunk == 0) ? 1'b1 : bit'($urandom_range(0, 1));
      run_frames(45, 8, 1'b0);
    end
  endtask

  task automatic test_quiet_tail();
    set_limit(LIMIT_RESET);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_frames(80, 6, 1'b0);
  endtask

  initial begin
    clear_frame();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_channel_extremes();
    test_extended_format();
    test_bad_characters();
    test_frame_end_errors();
    test_limit_sweep();
    test_backpressure();
    test_random_traffic();
    test_quiet_tail();
    drain();
    $display("sent %0d characters in %0d frames, checked %0d results",
             chars_sent, frames_sent, results_checked);
    $display("delay limits 0, 1, 3000, 65535 and random; base and extended formats; long hold");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/cwfdc_pkg.sv
src/cw_frame_delay_checker_core.sv
tb/cw_frame_delay_checker_core_tb.sv
